// ----- hw/rtl/cmdq_pkg.sv -----
// Shared types, constants and helpers for the coalescing command queue
`default_nettype none

package cmdq_pkg;

	localparam int QUEUE_DEPTH = 8;
	// slot address, count and wrap-sum widths
	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	localparam logic [3:0] KIND_LAST_PLAIN = 4'd6;
	localparam logic [3:0] KIND_DAY_STATE  = 4'd7;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [2:0] {
		ST_APPENDED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_REPLACED  = 3'd2,
		ST_FULL      = 3'd3,
		ST_POPPED    = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef struct packed {
		logic        command;
		logic [31:0] cmd_id;
		logic [3:0]  cmd_kind;
		logic [15:0] cmd_date;
		logic [31:0] cmd_payload;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] out_id;
		logic [3:0]  out_kind;
		logic [15:0] out_date;
		logic [31:0] out_payload;
		logic [3:0]  fill_level;
	} rsp_t;

	typedef struct packed {
		logic [31:0] id;
		logic [3:0]  kind;
		logic [15:0] date;
		logic [31:0] payload;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// circular slot address: base plus offset, folded once into the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [CW-1:0] offs);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(offs);
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// a queued entry takes over a new command of the same plain kind, or a day-state command with an equal nonzero date
	function automatic logic absorbs(input entry_t e, input logic [3:0] kind,
		input logic [15:0] date);
		logic hit;
		hit = 1'b0;
		if (e.kind == kind) begin
			if (kind <= KIND_LAST_PLAIN) begin
				hit = 1'b1;
			end else if (kind == KIND_DAY_STATE) begin
				hit = (date != 16'd0) && (e.date == date);
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cmdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module cmdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/coalescing_command_queue.sv -----
// A push first scans the queued entries; a pop reads the head slot, an empty pop reads none.
// Throughput: one command at a time; the entry scan reads one RAM slot per cycle.
// The next command is taken once the result sits in the output register.
// Reset clears the fill count, the head pointer and all handshake state; the entry
// RAM is not cleared, only slots below the fill count are ever read.
`default_nettype none

module coalescing_command_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire cmdq_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output cmdq_pkg::rsp_t      rsp
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_POP  = 5'b00100,
		S_POPD = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                      state_q, state_d;
	cmdq_pkg::cmd_t              cmd_q;
	logic [cmdq_pkg::AW-1:0]     head_q, head_d;
	logic [cmdq_pkg::CW-1:0]     count_q, count_d;
	logic [cmdq_pkg::CW-1:0]     issue_q;
	logic                        rvalid_s1;
	logic [cmdq_pkg::CW-1:0]     idx_s1;
	logic [cmdq_pkg::AW-1:0]     addr_s1;
	logic                        abs_found_q;
	logic [cmdq_pkg::AW-1:0]     abs_addr_q;
	cmdq_pkg::rsp_t              res_q, res_d;
	cmdq_pkg::rsp_t              rsp_q;
	logic                        rsp_valid_q;

	logic                        we_c;
	logic [cmdq_pkg::AW-1:0]     waddr_c, raddr_c;
	logic [cmdq_pkg::ENTRY_W-1:0] rdata;
	cmdq_pkg::entry_t            ent, new_ent;
	logic                        accept, rsp_take, out_free;
	logic                        dup_c, abs_c, last_s1, scan_end, issue_c;

	assign accept    = cmd_valid && !cmd_stall;
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// entry store
	cmdq_ram #(
		.WIDTH(cmdq_pkg::ENTRY_W),
		.DEPTH(cmdq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(new_ent),
		.raddr(raddr_c),
		.rdata(rdata)
	);

	assign ent     = cmdq_pkg::entry_t'(rdata);
	assign new_ent = '{id: cmd_q.cmd_id, kind: cmd_q.cmd_kind, date: cmd_q.cmd_date,
		payload: cmd_q.cmd_payload};

	// compare of the slot read in the previous cycle
	assign dup_c    = rvalid_s1 && (ent.id == cmd_q.cmd_id);
	assign abs_c    = rvalid_s1 && cmdq_pkg::absorbs(ent, cmd_q.cmd_kind, cmd_q.cmd_date);
	assign last_s1  = (idx_s1 == (count_q - cmdq_pkg::CW'(1)));
	assign scan_end = (state_q == S_SCAN) && (dup_c || (rvalid_s1 && last_s1) ||
		(!rvalid_s1 && (count_q == '0)));
	assign issue_c  = (state_q == S_SCAN) && (issue_q < count_q) && !scan_end;
	assign raddr_c  = (state_q == S_POP) ? head_q : cmdq_pkg::wrap_add(head_q, issue_q);

	// next state, queue pointers, RAM write and result
	always_comb begin
		state_d = state_q;
		head_d  = head_q;
		count_d = count_q;
		res_d   = res_q;
		we_c    = 1'b0;
		waddr_c = cmdq_pkg::wrap_add(head_q, count_q);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d = '0;
					if (cmd.command == cmdq_pkg::CMD_POP) begin
						if (count_q == '0) begin
							res_d.status = cmdq_pkg::ST_EMPTY;
							state_d = S_DONE;
						end else begin
							state_d = S_POP;
						end
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (scan_end) begin
					state_d = S_DONE;
					if (dup_c) begin
						res_d.status = cmdq_pkg::ST_DUPLICATE;
					end else if (abs_found_q || abs_c) begin
						we_c = 1'b1;
						waddr_c = abs_found_q ? abs_addr_q : addr_s1;
						res_d.status = cmdq_pkg::ST_REPLACED;
					end else if (count_q >= cmdq_pkg::CW'(cmdq_pkg::QUEUE_DEPTH)) begin
						res_d.status = cmdq_pkg::ST_FULL;
					end else begin
						we_c = 1'b1;
						count_d = count_q + cmdq_pkg::CW'(1);
						res_d.status = cmdq_pkg::ST_APPENDED;
					end
					res_d.fill_level = 4'(count_d);
				end
			end
			S_POP: begin
				state_d = S_POPD;
			end
			S_POPD: begin
				head_d = cmdq_pkg::wrap_add(head_q, cmdq_pkg::CW'(1));
				count_d = count_q - cmdq_pkg::CW'(1);
				res_d.status = cmdq_pkg::ST_POPPED;
				res_d.out_id = ent.id;
				res_d.out_kind = ent.kind;
				res_d.out_date = ent.date;
				res_d.out_payload = ent.payload;
				res_d.fill_level = 4'(count_d);
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			rvalid_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
			abs_found_q <= 1'b0;
			issue_q     <= '0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			rvalid_s1 <= issue_c;
			if (accept) begin
				issue_q     <= '0;
				abs_found_q <= 1'b0;
			end else begin
				if (issue_c) begin
					issue_q <= issue_q + cmdq_pkg::CW'(1);
				end
				if (abs_c && !abs_found_q && (state_q == S_SCAN)) begin
					abs_found_q <= 1'b1;
				end
			end
			// output register: load from the finished result, clear on a taken beat
			if ((state_q == S_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_take) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			cmd_q <= cmd;
		end
		if (issue_c) begin
			idx_s1  <= issue_q;
			addr_s1 <= raddr_c;
		end
		if (abs_c && !abs_found_q) begin
			abs_addr_q <= addr_s1;
		end
		if ((state_q == S_DONE) && out_free) begin
			rsp_q <= res_q;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/cmdq_checker.sv -----
// Port-level checks for the coalescing command queue, bound to the top level
`default_nettype none

module cmdq_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           cmd_valid,
	input wire logic           cmd_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire cmdq_pkg::rsp_t rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result beat changed while stalled");

	// one command at a time: the block is busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous one in flight");

	// only a pop carries entry fields
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != cmdq_pkg::ST_POPPED) |->
		(rsp.out_id == '0) && (rsp.out_kind == '0) && (rsp.out_date == '0) &&
		(rsp.out_payload == '0))
		else $error("non-pop result carries entry fields");

	// an empty pop reports an empty queue
	a_empty_level: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == cmdq_pkg::ST_EMPTY) |-> (rsp.fill_level == '0))
		else $error("empty result with nonzero fill level");

endmodule

bind coalescing_command_queue cmdq_checker u_cmdq_checker (.*);

`default_nettype wire

// ----- sim/coalescing_command_queue_tb.sv -----
// Self-checking testbench of the coalescing command queue: directed table, then random beats
`timescale 1ns / 100ps

module coalescing_command_queue_tb;

	localparam int LONG_HOLD   = 400;
	localparam int STUCK_LIMIT = 3000;
	localparam int TAIL_CYCLES = 16;
	localparam int CHUNK_ITEMS = 100;
	localparam int CHUNKS      = 17;

	typedef struct {
		cmdq_pkg::cmd_t c;
		bit             fixed;
		cmdq_pkg::rsp_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmdq_pkg::cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	cmdq_pkg::rsp_t rsp;

	// predicted queue contents
	cmdq_pkg::entry_t q_entries [cmdq_pkg::QUEUE_DEPTH];
	int q_count = 0;

	cmdq_pkg::rsp_t expected_rsp [$];
	cmdq_pkg::rsp_t oldest_rsp;
	directed_row_t directed [$];
	int mismatches = 0;

	// shared knobs of the idling processes
	int unsigned idle_pct = 20;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	coalescing_command_queue uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic cmdq_pkg::cmd_t mk_cmd(input logic op, input logic [31:0] id,
		input logic [3:0] kind, input logic [15:0] date, input logic [31:0] payload);
		cmdq_pkg::cmd_t c;
		c.command = op;
		c.cmd_id = id;
		c.cmd_kind = kind;
		c.cmd_date = date;
		c.cmd_payload = payload;
		return c;
	endfunction

	function automatic cmdq_pkg::rsp_t mk_rsp(input cmdq_pkg::status_t s,
		input logic [3:0] fill);
		cmdq_pkg::rsp_t r;
		r = '0;
		r.status = s;
		r.fill_level = fill;
		return r;
	endfunction

	// queue update and result of one command beat
	task automatic apply_command(input cmdq_pkg::cmd_t c, output cmdq_pkg::rsp_t r);
		int slot;
		bit hit;
		r = '0;
		if (c.command == cmdq_pkg::CMD_POP) begin
			if (q_count == 0) begin
				r.status = cmdq_pkg::ST_EMPTY;
			end else begin
				r.out_id = q_entries[0].id;
				r.out_kind = q_entries[0].kind;
				r.out_date = q_entries[0].date;
				r.out_payload = q_entries[0].payload;
				for (slot = 1; slot < q_count; slot++) begin
					q_entries[slot - 1] = q_entries[slot];
				end
				q_count--;
				r.status = cmdq_pkg::ST_POPPED;
			end
		end else begin
			hit = 1'b0;
			r.status = cmdq_pkg::ST_APPENDED;
			// an id already queued wins over everything
			for (slot = 0; slot < q_count && !hit; slot++) begin
				if (q_entries[slot].id == c.cmd_id) begin
					r.status = cmdq_pkg::ST_DUPLICATE;
					hit = 1'b1;
				end
			end
			// first entry that takes the command over is rewritten in place
			for (slot = 0; slot < q_count && !hit; slot++) begin
				if (q_entries[slot].kind == c.cmd_kind &&
					(c.cmd_kind <= cmdq_pkg::KIND_LAST_PLAIN ||
					(c.cmd_kind == cmdq_pkg::KIND_DAY_STATE && c.cmd_date != 16'd0 &&
					q_entries[slot].date == c.cmd_date))) begin
					q_entries[slot] = '{c.cmd_id, c.cmd_kind, c.cmd_date, c.cmd_payload};
					r.status = cmdq_pkg::ST_REPLACED;
					hit = 1'b1;
				end
			end
			if (!hit) begin
				if (q_count >= cmdq_pkg::QUEUE_DEPTH) begin
					r.status = cmdq_pkg::ST_FULL;
				end else begin
					q_entries[q_count] = '{c.cmd_id, c.cmd_kind, c.cmd_date, c.cmd_payload};
					q_count++;
				end
			end
		end
		r.fill_level = 4'(q_count);
	endtask

	// random beat, biased toward ids and dates that hit queued entries
	function automatic cmdq_pkg::cmd_t random_command(input int unsigned pop_pct);
		cmdq_pkg::cmd_t c;
		int unsigned pick;
		c.command = ($urandom_range(0, 99) < pop_pct) ? cmdq_pkg::CMD_POP : cmdq_pkg::CMD_PUSH;
		pick = $urandom_range(0, 99);
		if (pick < 15 && q_count > 0) begin
			c.cmd_id = q_entries[$urandom_range(0, q_count - 1)].id;
		end else if (pick < 22) begin
			c.cmd_id = 32'($urandom_range(0, 3));
		end else if (pick < 25) begin
			c.cmd_id = 32'hFFFF_FFFF;
		end else begin
			c.cmd_id = $urandom;
		end
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			c.cmd_kind = 4'($urandom_range(0, 6));
		end else if (pick < 80) begin
			c.cmd_kind = cmdq_pkg::KIND_DAY_STATE;
		end else if (pick < 92) begin
			c.cmd_kind = 4'd8;
		end else begin
			c.cmd_kind = 4'($urandom_range(9, 15));
		end
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			c.cmd_date = 16'd0;
		end else if (pick < 75) begin
			c.cmd_date = 16'($urandom_range(1, 3));
		end else begin
			c.cmd_date = 16'($urandom);
		end
		c.cmd_payload = $urandom;
		return c;
	endfunction

	// offer one beat, hold it until taken, then maybe leave a gap
	task automatic send_command(input cmdq_pkg::cmd_t c, input bit fixed,
		input cmdq_pkg::rsp_t fixed_rsp);
		cmdq_pkg::rsp_t want;
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) begin
			@(posedge clk);
		end
		apply_command(c, want);
		expected_rsp.push_back(fixed ? fixed_rsp : want);
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic note_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch in %s: expected %h, got %h", field, want, got);
			end
		end
	endtask

	// result side stalls, with one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				rsp_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 299) < idle_pct) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result with nothing expected: %p", rsp);
				end
			end else begin
				oldest_rsp = expected_rsp.pop_front();
				note_field("status", oldest_rsp.status, rsp.status);
				note_field("out_id", oldest_rsp.out_id, rsp.out_id);
				note_field("out_kind", oldest_rsp.out_kind, rsp.out_kind);
				note_field("out_date", oldest_rsp.out_date, rsp.out_date);
				note_field("out_payload", oldest_rsp.out_payload, rsp.out_payload);
				note_field("fill_level", oldest_rsp.fill_level, rsp.fill_level);
			end
		end
	end

	// watchdog on cycles with no beat on either side
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
				stuck = 0;
			end else begin
				stuck++;
			end
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int row;
		int chunk;
		int n;
		int unsigned pop_pct;
		cmdq_pkg::rsp_t none;
		none = '0;

		// extremes, duplicates, coalescing rules, full and empty queue
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_POP, 0, 0, 0, 0), 1,
			mk_rsp(cmdq_pkg::ST_EMPTY, 0)});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 0, 0, 0, 0), 1,
			mk_rsp(cmdq_pkg::ST_APPENDED, 1)});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 8, 16'hFFFF,
			32'hFFFF_FFFF), 1, mk_rsp(cmdq_pkg::ST_APPENDED, 2)});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 0, 8, 1, 1), 1,
			mk_rsp(cmdq_pkg::ST_DUPLICATE, 2)});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 5, 0, 0, 32'hA5A5_A5A5), 0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 6, cmdq_pkg::KIND_DAY_STATE, 100, 1),
			0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 7, cmdq_pkg::KIND_DAY_STATE, 100, 2),
			0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 8, cmdq_pkg::KIND_DAY_STATE, 0, 3),
			0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 9, cmdq_pkg::KIND_DAY_STATE, 0, 4),
			0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 10, cmdq_pkg::KIND_DAY_STATE, 101, 5),
			0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 11, 15, 0, 6), 0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 12, 15, 0, 7), 0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 13, 9, 0, 8), 1,
			mk_rsp(cmdq_pkg::ST_FULL, 8)});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 14, 6, 0, 9), 0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 15, 0, 0, 32'h0000_AAAA), 0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 3, 2, 10), 0, none});
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_PUSH, 16, cmdq_pkg::KIND_DAY_STATE, 101, 11),
			0, none});
		for (row = 0; row < cmdq_pkg::QUEUE_DEPTH; row++) begin
			directed.push_back('{mk_cmd(cmdq_pkg::CMD_POP, $urandom, 4'($urandom),
				16'($urandom), $urandom), 0, none});
		end
		directed.push_back('{mk_cmd(cmdq_pkg::CMD_POP, 0, 0, 0, 0), 1,
			mk_rsp(cmdq_pkg::ST_EMPTY, 0)});

		// reset once, released on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_command(directed[i].c, directed[i].fixed, directed[i].want);
		end

		// random phases swinging between full and empty
		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			case (chunk % 5)
				0: pop_pct = 10;
				1: pop_pct = 30;
				2: pop_pct = 50;
				3: pop_pct = 70;
				default: pop_pct = 90;
			endcase
			case (chunk % 3)
				0: idle_pct = 20;
				1: idle_pct = 0;
				default: idle_pct = 50;
			endcase
			if (chunk == 3) begin
				long_hold = 1'b1;
			end
			// sender waits for every outstanding result
			if (chunk == 6) begin
				cmd_valid <= 1'b0;
				while (expected_rsp.size() != 0) begin
					@(posedge clk);
				end
			end
			if (chunk >= CHUNKS - 2) begin
				quiet = 1'b1;
			end
			for (n = 0; n < CHUNK_ITEMS; n++) begin
				send_command(random_command(pop_pct), 1'b0, none);
			end
		end

		// drain and settle
		cmd_valid <= 1'b0;
		while (expected_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
